[rtl/core/htc_pkg.sv]
package htc_pkg;

  // Field widths.
  localparam int HEAD_W    = 17;
  localparam int GYRO_W    = 16;
  localparam int VEL_W     = 17;
  localparam int GAIN_W    = 24;
  localparam int MAXV_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int ERR_W     = 19;
  localparam int ERR_MAG_W = 18;
  localparam int EFFORT_W  = 16;

  localparam int SPEED_WIDTH_DEF = 16;

  // Angles in centidegrees.
  localparam logic signed [ERR_W-1:0]   HALF_TURN = 19'sd18000;
  localparam logic signed [ERR_W-1:0]   FULL_TURN = 19'sd36000;
  localparam logic [ERR_MAG_W-1:0]      DONE_LOW  = 18'd10;
  localparam logic [ERR_MAG_W-1:0]      DONE_HIGH = 18'd35990;

  // Q1.15 value of 1.0.
  localparam logic [EFFORT_W-1:0] U_ONE = 16'h8000;

  // Register reset values and indexes.
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 24'd1073742;
  localparam logic [MAXV_W-1:0]    MAXV_RESET = 16'hFFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXV   = 1'b1;

  // Item kinds.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Wrap modes.
  localparam logic [1:0] WRAP_NONE = 2'd0;
  localparam logic [1:0] WRAP_POS  = 2'd1;
  localparam logic [1:0] WRAP_NEG  = 2'd2;

  typedef struct packed {
    logic       spin;
    logic [1:0] wrap;
  } arc_t;

endpackage

[rtl/core/htc_mul.sv]
module htc_mul #(
  parameter int AW = 18,
  parameter int BW = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  // Shared unsigned multiplier with a registered product.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (AW+BW)'(a) * (AW+BW)'(b);
    end
  end

endmodule

[rtl/core/htc_arc.sv]
module htc_arc #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic signed [htc_pkg::HEAD_W-1:0] tgt,
  input  logic signed [htc_pkg::VEL_W-1:0]  spd,
  input  logic [htc_pkg::GYRO_W-1:0]        gyro,
  input  logic [htc_pkg::MAXV_W-1:0]        max_vel,
  output htc_pkg::arc_t                     arc,
  output logic [SPEED_WIDTH-1:0]            speed
);
  import htc_pkg::*;

  localparam int LW = (SPEED_WIDTH > MAXV_W) ? SPEED_WIDTH : MAXV_W;

  logic signed [ERR_W-1:0] diff;
  logic                    far;
  logic                    ahead;
  logic [VEL_W:0]          neg_spd;
  logic [VEL_W-1:0]        mag;
  logic [MAXV_W-1:0]       lim;
  logic [LW-1:0]           lim_ext;
  logic [LW-1:0]           cap;

  always_comb begin
    diff  = ERR_W'(tgt) - $signed(ERR_W'({1'b0, gyro}));
    far   = (diff > HALF_TURN) || (diff < -HALF_TURN);
    ahead = diff > 0;
    arc.spin = ahead ? far : !far;
    if (!far) begin
      arc.wrap = WRAP_NONE;
    end else if (ahead) begin
      arc.wrap = WRAP_POS;
    end else begin
      arc.wrap = WRAP_NEG;
    end

    // Absolute value, then the register limit, then the width cap.
    neg_spd = -(VEL_W+1)'(spd);
    mag     = spd[VEL_W-1] ? neg_spd[VEL_W-1:0] : spd;
    lim     = (mag > VEL_W'(max_vel)) ? max_vel : mag[MAXV_W-1:0];
    lim_ext = LW'(lim);
    cap     = (LW'(1) << SPEED_WIDTH) - LW'(1);
    speed   = (lim_ext > cap) ? cap[SPEED_WIDTH-1:0] : lim_ext[SPEED_WIDTH-1:0];
  end

endmodule

[rtl/core/heading_turn_controller.sv]
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser: action; s_tdata: target, speed, gyro
// m        out  m_tvalid/m_tready  m_tdata: left, right, spin, active, done
// cfg      in   cfg_we             cfg_index selects gain (0) or speed limit (1)
//
// Every accepted item yields exactly one result. A start item, a tick while idle
// and a finishing tick go from S_EVAL to S_OUT; a wheel-driving tick adds S_MUL1,
// S_MUL2 and S_SIGN, as the one shared multiplier forms the gain product and then
// the wheel product in turn. s_tready is high only while the sequencer idles.
// Reset is synchronous and active high; it restores the register defaults and
// leaves the block idle. A result waiting on m_tready holds the sequencer in its
// output step, while the previous result may still sit in the output register.
module heading_turn_controller #(
  parameter int SPEED_WIDTH = htc_pkg::SPEED_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [55:0]                   s_tdata,  // target_heading, turn_speed, gyro_heading
  input  logic [0:0]                    s_tuser,  // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [39:0]                   m_tdata,  // left_velocity, right_velocity,
                                                  // spin_clockwise, active, done_res
  input  logic                          cfg_we,
  input  logic [htc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [htc_pkg::GAIN_W-1:0]    cfg_data
);
  import htc_pkg::*;

  localparam int BW = (SPEED_WIDTH > GAIN_W) ? SPEED_WIDTH : GAIN_W;
  localparam int PW = ERR_MAG_W + BW;
  localparam int UW = PW - 16;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_SIGN = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;

  // Configuration registers.
  logic [GAIN_W-1:0] prop_gain;
  logic [MAXV_W-1:0] max_velocity;

  // Latched input item.
  logic                     in_action;
  logic signed [HEAD_W-1:0] in_tgt;
  logic signed [VEL_W-1:0]  in_spd;
  logic [GYRO_W-1:0]        in_gyro;

  // Turn state.
  logic                     turning;
  logic signed [HEAD_W-1:0] goal_heading;
  logic [1:0]               wrap_mode;
  logic [SPEED_WIDTH-1:0]   limited_speed;
  logic                     spin_sense;

  // Working values of one item.
  logic                 err_neg;
  logic [ERR_MAG_W-1:0] aerr;
  logic [VEL_W-1:0]     res_right;
  logic                 res_done;

  // Output register.
  logic [VEL_W-1:0] out_left;
  logic [VEL_W-1:0] out_right;
  logic             out_spin;
  logic             out_active;
  logic             out_done;

  arc_t                   arc;
  logic [SPEED_WIDTH-1:0] arc_speed;

  htc_arc #(.SPEED_WIDTH(SPEED_WIDTH)) u_arc (
    .tgt     (in_tgt),
    .spd     (in_spd),
    .gyro    (in_gyro),
    .max_vel (max_velocity),
    .arc     (arc),
    .speed   (arc_speed)
  );

  // Heading error with the wrap correction.
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] err_fix;
  logic [1:0]              wrap_next;
  logic signed [ERR_W-1:0] gyro_s;
  logic signed [ERR_W-1:0] goal_s;
  logic [ERR_W-1:0]        err_abs;
  logic                    is_done;

  always_comb begin
    gyro_s    = $signed(ERR_W'({1'b0, in_gyro}));
    goal_s    = ERR_W'(goal_heading);
    err       = goal_s - gyro_s;
    err_fix   = err;
    wrap_next = wrap_mode;
    case (wrap_mode)
      WRAP_POS: begin
        if (gyro_s < goal_s) begin
          err_fix = err - FULL_TURN;
        end else begin
          wrap_next = WRAP_NONE;
        end
      end
      WRAP_NEG: begin
        if (gyro_s > goal_s) begin
          err_fix = err + FULL_TURN;
        end else begin
          wrap_next = WRAP_NONE;
        end
      end
      default: begin
        wrap_next = WRAP_NONE;
      end
    endcase
    err_abs = err_fix[ERR_W-1] ? ERR_W'(-err_fix) : ERR_W'(err_fix);
    is_done = (err_abs[ERR_MAG_W-1:0] < DONE_LOW) || (err_abs[ERR_MAG_W-1:0] > DONE_HIGH);
  end

  // The shared multiplier: gain times error, then speed times effort.
  logic [PW-1:0]        prod;
  logic [ERR_MAG_W-1:0] mul_a;
  logic [BW-1:0]        mul_b;
  logic [UW-1:0]        u_raw;
  logic [EFFORT_W-1:0]  u_clamp;
  logic [VEL_W-1:0]     vmag;

  always_comb begin
    u_raw   = prod[PW-1:16];
    u_clamp = (u_raw > UW'(U_ONE)) ? U_ONE : u_raw[EFFORT_W-1:0];
    vmag    = prod[VEL_W+14:15];
    if (state == S_MUL1) begin
      mul_a = aerr;
      mul_b = BW'(prop_gain);
    end else begin
      mul_a = ERR_MAG_W'(u_clamp);
      mul_b = BW'(limited_speed);
    end
  end

  htc_mul #(.AW(ERR_MAG_W), .BW(BW)) u_mul (
    .clk (clk),
    .en  ((state == S_MUL1) || (state == S_MUL2)),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign s_tready = (state == S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= GAIN_RESET;
      max_velocity <= MAXV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN: prop_gain    <= cfg_data;
        CFG_MAXV: max_velocity <= cfg_data[MAXV_W-1:0];
        default:  prop_gain    <= prop_gain;
      endcase
    end
  end

  // Sequencer and turn state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      turning       <= 1'b0;
      goal_heading  <= '0;
      wrap_mode     <= WRAP_NONE;
      limited_speed <= '0;
      spin_sense    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_action <= s_tuser[0];
            in_tgt    <= s_tdata[HEAD_W-1:0];
            in_spd    <= s_tdata[HEAD_W+VEL_W-1:HEAD_W];
            in_gyro   <= s_tdata[HEAD_W+VEL_W+GYRO_W-1:HEAD_W+VEL_W];
            state     <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_right <= '0;
          res_done  <= 1'b0;
          err_neg   <= err_fix[ERR_W-1];
          aerr      <= err_abs[ERR_MAG_W-1:0];
          if (in_action == ACT_START) begin
            goal_heading  <= in_tgt;
            limited_speed <= arc_speed;
            spin_sense    <= arc.spin;
            wrap_mode     <= arc.wrap;
            turning       <= 1'b1;
            state         <= S_OUT;
          end else if (!turning) begin
            state <= S_OUT;
          end else begin
            wrap_mode <= wrap_next;
            if (is_done) begin
              turning  <= 1'b0;
              res_done <= 1'b1;
              state    <= S_OUT;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_SIGN;
        end
        S_SIGN: begin
          res_right <= err_neg ? -vmag : vmag;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload, loaded together with m_tvalid.
  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      out_left   <= -res_right;
      out_right  <= res_right;
      out_spin   <= spin_sense;
      out_active <= turning;
      out_done   <= res_done;
    end
  end

  assign m_tdata = {3'b000, out_done, out_active, out_spin, out_right, out_left};

endmodule

[rtl/core/htc_check.sv]
module htc_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // One item at a time: the input closes right after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // The left velocity is always the negated right velocity.
  a_mirror: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[16:0] + m_tdata[33:17]) == 17'd0))
    else $error("left velocity is not the negated right velocity");

  // A finishing result stops the wheels and ends the turn.
  a_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[36]) |-> ((m_tdata[33:0] == 34'd0) && !m_tdata[35]))
    else $error("finished turn with wheels moving or still active");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

endmodule

bind heading_turn_controller htc_check u_htc_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
